@@ sv/lpr_pkg.sv @@
// ----------------------------------------------------------------------------
// LRU page replacement package
// Shared constants, state type and the structs that link the frame cells.
// ----------------------------------------------------------------------------
package lpr_pkg;

   localparam int FRAME_SLOTS = 8;
   localparam int PAGE_BITS   = 8;
   localparam int SLOT_BITS   = 3;
   localparam int RANK_BITS   = 3;
   localparam int COUNT_BITS  = 4;
   localparam int FAULT_BITS  = 16;
   localparam int DATA_BITS   = 32;
   localparam int ADDR_BITS   = 3;

   localparam logic [FAULT_BITS-1:0] FAULT_MAX = '1;
   localparam logic [COUNT_BITS-1:0] FRAMES_RESET = COUNT_BITS'(FRAME_SLOTS);
   localparam logic [0:0] REG_FRAMES_IN_USE = 1'b0;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_UPDATE
   } lpr_state_type;

   typedef struct packed {
      logic                 hit_found;
      logic [SLOT_BITS-1:0] hit_slot;
      logic [RANK_BITS-1:0] hit_rank;
      logic                 free_found;
      logic [SLOT_BITS-1:0] free_slot;
      logic                 old_found;
      logic [RANK_BITS-1:0] old_rank;
      logic [SLOT_BITS-1:0] old_slot;
      logic [PAGE_BITS-1:0] old_page;
   } lpr_chain_type;

   typedef struct packed {
      logic                 enable;
      logic [SLOT_BITS-1:0] slot;
      logic                 fill;
      logic [PAGE_BITS-1:0] page;
      logic                 age_all;
      logic [RANK_BITS-1:0] limit;
   } lpr_update_type;

endpackage

@@ sv/lpr_cell.sv @@
// ----------------------------------------------------------------------------
// LRU page replacement frame cell
// Holds one frame, extends the lookup chain from its neighbor and applies
// the recency update.
// ----------------------------------------------------------------------------
module lpr_cell
   import lpr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic [SLOT_BITS-1:0] slot_id,
   input  logic                 in_use,
   input  logic [PAGE_BITS-1:0] lookup_page,
   input  lpr_chain_type        chain_in,
   output lpr_chain_type        chain_out,
   input  lpr_update_type       update,
   output logic                 frame_valid
);

   logic                 valid_ff, valid_in;
   logic [PAGE_BITS-1:0] page_ff, page_in;
   logic [RANK_BITS-1:0] rank_ff, rank_in;
   logic                 match;
   logic                 take_old;

   assign match    = in_use && valid_ff && (page_ff == lookup_page);
   assign take_old = in_use && (!chain_in.old_found || (rank_ff > chain_in.old_rank));

   always_comb begin
      chain_out            = chain_in;
      chain_out.hit_found  = chain_in.hit_found || match;
      chain_out.free_found = chain_in.free_found || (in_use && !valid_ff);
      chain_out.old_found  = chain_in.old_found || in_use;
      if (!chain_in.hit_found && match) begin
         chain_out.hit_slot = slot_id;
         chain_out.hit_rank = rank_ff;
      end
      if (!chain_in.free_found && in_use && !valid_ff) begin
         chain_out.free_slot = slot_id;
      end
      if (take_old) begin
         chain_out.old_rank = rank_ff;
         chain_out.old_slot = slot_id;
         chain_out.old_page = page_ff;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      page_in  = page_ff;
      rank_in  = rank_ff;
      if (update.enable) begin
         if (update.slot == slot_id) begin
            rank_in = '0;
            if (update.fill) begin
               valid_in = 1'b1;
               page_in  = update.page;
            end
         end else if (valid_ff && (update.age_all || (rank_ff < update.limit))) begin
            rank_in = rank_ff + RANK_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rank_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         rank_ff  <= rank_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff <= page_in;
   end

   assign frame_valid = valid_ff;

endmodule

@@ sv/lru_page_replacement.sv @@
// ----------------------------------------------------------------------------
// LRU page replacement
// A taken start runs the lookup pass through the frame chain in the lookup
// state, then the recency update of all cells in the update state, where a
// new start is also taken; the result strobe is registered from the update.
// Reset: all frames empty, ranks and fault count zero, eight frames in use.
// ----------------------------------------------------------------------------
module lru_page_replacement
   import lpr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [PAGE_BITS-1:0]  req_page_number,
   output logic                  rsp_valid,
   output logic                  rsp_hit,
   output logic [SLOT_BITS-1:0]  rsp_frame_slot,
   output logic                  rsp_evicted_valid,
   output logic [PAGE_BITS-1:0]  rsp_evicted_page,
   output logic [FAULT_BITS-1:0] rsp_fault_total,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [ADDR_BITS-1:0]  paddr,
   input  logic [DATA_BITS-1:0]  pwdata,
   output logic [DATA_BITS-1:0]  prdata,
   output logic                  pready
);

   lpr_state_type state_ff, state_in;

   logic                  accept;
   logic                  lookup_en;
   logic                  update_en;
   logic [COUNT_BITS-1:0] frames_ff;
   logic [COUNT_BITS-1:0] active_n;
   logic [PAGE_BITS-1:0]  page_ff;
   logic [FAULT_BITS-1:0] fault_count_ff, fault_count_in;

   logic                  dec_hit_ff;
   logic [SLOT_BITS-1:0]  dec_slot_ff;
   logic                  dec_evict_ff;
   logic [PAGE_BITS-1:0]  dec_evpage_ff;
   logic [RANK_BITS-1:0]  dec_limit_ff;
   logic                  dec_age_all_ff;

   logic                  rsp_valid_ff;
   logic                  rsp_hit_ff;
   logic [SLOT_BITS-1:0]  rsp_slot_ff;
   logic                  rsp_evict_ff;
   logic [PAGE_BITS-1:0]  rsp_evpage_ff;
   logic [FAULT_BITS-1:0] rsp_fault_ff;

   lpr_chain_type         chain [FRAME_SLOTS+1];
   lpr_chain_type         chain_end;
   lpr_update_type        update;
   logic [FRAME_SLOTS-1:0] in_use;
   logic [FRAME_SLOTS-1:0] frame_valid;

   assign accept = start && !busy;

   always_comb begin
      unique case (state_ff)
         ST_IDLE:   state_in = start ? ST_LOOKUP : ST_IDLE;
         ST_LOOKUP: state_in = ST_UPDATE;
         ST_UPDATE: state_in = start ? ST_LOOKUP : ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      busy      = 1'b0;
      lookup_en = 1'b0;
      update_en = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
         end
         ST_LOOKUP: begin
            busy      = 1'b1;
            lookup_en = 1'b1;
         end
         ST_UPDATE: begin
            update_en = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_ff <= FRAMES_RESET;
      end else if (psel && penable && pwrite && (paddr[2] == REG_FRAMES_IN_USE)) begin
         frames_ff <= pwdata[COUNT_BITS-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == REG_FRAMES_IN_USE) begin
         prdata = DATA_BITS'(frames_ff);
      end
   end

   always_comb begin
      if (frames_ff == '0) begin
         active_n = COUNT_BITS'(1);
      end else if (frames_ff > COUNT_BITS'(FRAME_SLOTS)) begin
         active_n = COUNT_BITS'(FRAME_SLOTS);
      end else begin
         active_n = frames_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         page_ff <= req_page_number;
      end
   end

   assign chain[0] = '0;

   for (genvar i = 0; i < FRAME_SLOTS; i++) begin : g_cell
      assign in_use[i] = COUNT_BITS'(i) < active_n;

      lpr_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .slot_id     (SLOT_BITS'(i)),
         .in_use      (in_use[i]),
         .lookup_page (page_ff),
         .chain_in    (chain[i]),
         .chain_out   (chain[i+1]),
         .update      (update),
         .frame_valid (frame_valid[i])
      );
   end

   assign chain_end = chain[FRAME_SLOTS];

   always_ff @(posedge clock) begin
      if (lookup_en) begin
         dec_hit_ff     <= chain_end.hit_found;
         dec_evict_ff   <= !chain_end.hit_found && !chain_end.free_found;
         dec_age_all_ff <= !chain_end.hit_found && chain_end.free_found;
         if (chain_end.hit_found) begin
            dec_slot_ff  <= chain_end.hit_slot;
            dec_limit_ff <= chain_end.hit_rank;
         end else if (chain_end.free_found) begin
            dec_slot_ff  <= chain_end.free_slot;
            dec_limit_ff <= chain_end.old_rank;
         end else begin
            dec_slot_ff  <= chain_end.old_slot;
            dec_limit_ff <= chain_end.old_rank;
         end
         if (!chain_end.hit_found && !chain_end.free_found) begin
            dec_evpage_ff <= chain_end.old_page;
         end else begin
            dec_evpage_ff <= '0;
         end
      end
   end

   always_comb begin
      update.enable  = update_en;
      update.slot    = dec_slot_ff;
      update.fill    = !dec_hit_ff;
      update.page    = page_ff;
      update.age_all = dec_age_all_ff;
      update.limit   = dec_limit_ff;
   end

   always_comb begin
      fault_count_in = fault_count_ff;
      if (update_en && !dec_hit_ff && (fault_count_ff != FAULT_MAX)) begin
         fault_count_in = fault_count_ff + FAULT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fault_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         fault_count_ff <= fault_count_in;
         rsp_valid_ff   <= update_en;
      end
   end

   always_ff @(posedge clock) begin
      if (update_en) begin
         rsp_hit_ff    <= dec_hit_ff;
         rsp_slot_ff   <= dec_slot_ff;
         rsp_evict_ff  <= dec_evict_ff;
         rsp_evpage_ff <= dec_evpage_ff;
         rsp_fault_ff  <= fault_count_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_frame_slot    = rsp_slot_ff;
   assign rsp_evicted_valid = rsp_evict_ff;
   assign rsp_evicted_page  = rsp_evpage_ff;
   assign rsp_fault_total   = rsp_fault_ff;

`ifndef SYNTH
   a_lookup_then_update: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOOKUP |=> state_ff == ST_UPDATE)
      else $error("lookup not followed by update");

   a_strobe_after_update: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_UPDATE))
      else $error("result strobe without an update");

   a_fault_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_fault_total != '0)
      else $error("fault reported with a zero fault total");

   a_evict_only_when_full: assert property (@(posedge clock) disable iff (reset)
      update_en && dec_evict_ff |-> &(frame_valid | ~in_use))
      else $error("eviction while a frame in use is free");
`endif

endmodule
